// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the timer bank RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/stb_pkg.sv
// ----------------------------------------------------------------------------
// Timer bank package
// Shared constants, codes, types and helper functions of the timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

   // Fixed field widths of the ports.
   localparam int TIME_BITS      = 32;
   localparam int TAG_PORT_BITS  = 16;
   localparam int SLOT_PORT_BITS = 4;
   localparam int KIND_BITS      = 2;

   // Request operations.
   localparam logic OP_CREATE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // Response kinds.
   localparam logic [KIND_BITS-1:0] KIND_ACCEPTED = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_FULL     = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_EXPIRED  = 2'd2;

   // Per-cycle controls broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;  // push a new timer in at the head
      logic rotate;  // shift the whole chain one place toward the head
      logic arm;     // mark every cell as not yet visited by this tick
   } stb_cell_ctrl_type;

   // Unsigned add that saturates at the all-ones value.
   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                    input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
   endfunction

endpackage

// File: rtl/core/stb_cell.sv
// ----------------------------------------------------------------------------
// Timer cell
// One place of the age-ordered timer chain. It takes a new entry from its
// lower neighbor on an insert and from its upper neighbor on a rotation.
// ----------------------------------------------------------------------------
module stb_cell #(
   parameter int SLOT_BITS = 4,
   parameter int TAG_W     = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  stb_pkg::stb_cell_ctrl_type        ctrl,
   input  logic [stb_pkg::TIME_BITS-1:0]     now_seconds,
   input  logic                              chain_all_live_in,
   output logic                              chain_all_live_out,
   input  logic                              ins_live,
   input  logic                              ins_periodic,
   input  logic [SLOT_BITS-1:0]              ins_slot,
   input  logic [TAG_W-1:0]                  ins_tag,
   input  logic [stb_pkg::TIME_BITS-1:0]     ins_deadline,
   input  logic [stb_pkg::TIME_BITS-1:0]     ins_reload,
   input  logic                              rot_live,
   input  logic                              rot_mark,
   input  logic                              rot_periodic,
   input  logic [SLOT_BITS-1:0]              rot_slot,
   input  logic [TAG_W-1:0]                  rot_tag,
   input  logic [stb_pkg::TIME_BITS-1:0]     rot_deadline,
   input  logic [stb_pkg::TIME_BITS-1:0]     rot_reload,
   output logic                              cur_live,
   output logic                              cur_mark,
   output logic                              cur_periodic,
   output logic [SLOT_BITS-1:0]              cur_slot,
   output logic [TAG_W-1:0]                  cur_tag,
   output logic [stb_pkg::TIME_BITS-1:0]     cur_deadline,
   output logic [stb_pkg::TIME_BITS-1:0]     cur_reload,
   output logic                              pend
);

   logic                          live_ff;
   logic                          mark_ff;
   logic                          periodic_ff;
   logic [SLOT_BITS-1:0]          slot_ff;
   logic [TAG_W-1:0]              tag_ff;
   logic [stb_pkg::TIME_BITS-1:0] deadline_ff;
   logic [stb_pkg::TIME_BITS-1:0] reload_ff;
   logic                          take_ins;

   // An insert shifts every cell up to and including the first free one.
   assign take_ins           = ctrl.insert & chain_all_live_in;
   assign chain_all_live_out = chain_all_live_in & live_ff;

   // Control bits of the cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
         mark_ff <= 1'b0;
      end else if (ctrl.rotate) begin
         live_ff <= rot_live;
         mark_ff <= rot_mark;
      end else if (take_ins) begin
         live_ff <= ins_live;
         mark_ff <= 1'b0;
      end else if (ctrl.arm) begin
         mark_ff <= 1'b1;
      end
   end

   // Timer payload.
   always_ff @(posedge clock) begin
      if (ctrl.rotate) begin
         periodic_ff <= rot_periodic;
         slot_ff     <= rot_slot;
         tag_ff      <= rot_tag;
         deadline_ff <= rot_deadline;
         reload_ff   <= rot_reload;
      end else if (take_ins) begin
         periodic_ff <= ins_periodic;
         slot_ff     <= ins_slot;
         tag_ff      <= ins_tag;
         deadline_ff <= ins_deadline;
         reload_ff   <= ins_reload;
      end
   end

   // A live timer not yet visited by this tick is due once its deadline is reached.
   assign pend = live_ff & mark_ff & (deadline_ff <= now_seconds);

   assign cur_live     = live_ff;
   assign cur_mark     = mark_ff;
   assign cur_periodic = periodic_ff;
   assign cur_slot     = slot_ff;
   assign cur_tag      = tag_ff;
   assign cur_deadline = deadline_ff;
   assign cur_reload   = reload_ff;

endmodule

// File: rtl/core/stb_head.sv
// ----------------------------------------------------------------------------
// Timer chain head
// Processes the entry at the head of the chain during a tick scan: frees a
// due one-shot timer and reloads a due periodic timer before the entry
// wraps around to the tail.
// ----------------------------------------------------------------------------
module stb_head (
   input  logic                          head_live,
   input  logic                          head_periodic,
   input  logic                          head_pend,
   input  logic [stb_pkg::TIME_BITS-1:0] head_deadline,
   input  logic [stb_pkg::TIME_BITS-1:0] head_reload,
   input  logic [stb_pkg::TIME_BITS-1:0] now_seconds,
   output logic                          nxt_live,
   output logic [stb_pkg::TIME_BITS-1:0] nxt_deadline,
   output logic                          free_slot
);

   logic [stb_pkg::TIME_BITS-1:0] reload_deadline;

   // The next deadline of a periodic timer counts from the current time.
   assign reload_deadline = stb_pkg::sat_add(head_reload, now_seconds);

   // Retire or reload the head entry when it is due.
   always_comb begin
      nxt_live     = head_live;
      nxt_deadline = head_deadline;
      free_slot    = 1'b0;
      if (head_pend) begin
         if (head_periodic) begin
            nxt_deadline = reload_deadline;
         end else begin
            nxt_live  = 1'b0;
            free_slot = 1'b1;
         end
      end
   end

endmodule

// File: rtl/core/software_timer_bank.sv
// ----------------------------------------------------------------------------
// Software timer bank
// A bank of one-shot and periodic timers kept in a chain of cells, newest
// at the head. A tick rotates the chain once around and reports due timers.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+---------------------------------
//   req     | in        | req_valid/req_ready  | operation, timeout, periodic, tag
//   rsp     | out       | rsp_valid/rsp_ready  | kind, expired_tag, slot, last
//
// A create transaction answers through the output register.
// A tick transaction is accepted, then rotates the chain once around through the
// head unit, one place per cycle, pausing while a due timer is at the head and
// the output register is occupied.
// Reset is synchronous and clears the time, the slot busy bits and the cells.
// New requests are taken only when the scan is idle and the output register
// is empty or being emptied in the same cycle.
//
`include "assert_macros.svh"

module software_timer_bank #(
   parameter int NUM_TIMERS = 16,
   parameter int TAG_BITS   = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_operation,
   input  logic [stb_pkg::TIME_BITS-1:0]           req_timeout_seconds,
   input  logic                                    req_periodic,
   input  logic [stb_pkg::TAG_PORT_BITS-1:0]       req_timer_tag,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [stb_pkg::KIND_BITS-1:0]           rsp_kind,
   output logic [stb_pkg::TAG_PORT_BITS-1:0]       rsp_expired_tag,
   output logic [stb_pkg::SLOT_PORT_BITS-1:0]      rsp_slot_index,
   output logic                                    rsp_last
);

   localparam int SLOT_BITS = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int TAG_W     = (TAG_BITS < stb_pkg::TAG_PORT_BITS) ? TAG_BITS
                                                                 : stb_pkg::TAG_PORT_BITS;
   localparam logic [SLOT_BITS-1:0] LAST_STEP = SLOT_BITS'(NUM_TIMERS - 1);

   // Scan sequencer states.
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   localparam int TW = stb_pkg::TIME_BITS;

   logic                               state_ff, state_in;
   logic [SLOT_BITS-1:0]               step_ff, step_in;
   logic [TW-1:0]                      now_ff, now_in;
   logic [NUM_TIMERS-1:0]              busy_ff, busy_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [stb_pkg::KIND_BITS-1:0]      rsp_kind_ff, rsp_kind_in;
   logic [TAG_W-1:0]                   rsp_tag_ff, rsp_tag_in;
   logic [SLOT_BITS-1:0]               rsp_slot_ff, rsp_slot_in;
   logic                               rsp_last_ff, rsp_last_in;

   stb_pkg::stb_cell_ctrl_type         ctrl;
   logic                               req_fire;
   logic                               out_free;
   logic                               table_full;
   logic [SLOT_BITS-1:0]               free_idx;
   logic [TAG_W-1:0]                   new_tag;
   logic [TW-1:0]                      new_deadline;

   // Chain signals, one entry per cell.
   logic [NUM_TIMERS:0]                all_live_chain;
   logic [NUM_TIMERS-1:0]              cell_live;
   logic [NUM_TIMERS-1:0]              cell_mark;
   logic [NUM_TIMERS-1:0]              cell_periodic;
   logic [NUM_TIMERS-1:0]              pend_vec;
   logic [SLOT_BITS-1:0]               cell_slot     [NUM_TIMERS];
   logic [TAG_W-1:0]                   cell_tag      [NUM_TIMERS];
   logic [TW-1:0]                      cell_deadline [NUM_TIMERS];
   logic [TW-1:0]                      cell_reload   [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]              ins_live;
   logic [NUM_TIMERS-1:0]              ins_periodic;
   logic [SLOT_BITS-1:0]               ins_slot      [NUM_TIMERS];
   logic [TAG_W-1:0]                   ins_tag       [NUM_TIMERS];
   logic [TW-1:0]                      ins_deadline  [NUM_TIMERS];
   logic [TW-1:0]                      ins_reload    [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]              rot_live;
   logic [NUM_TIMERS-1:0]              rot_mark;
   logic [NUM_TIMERS-1:0]              rot_periodic;
   logic [SLOT_BITS-1:0]               rot_slot      [NUM_TIMERS];
   logic [TAG_W-1:0]                   rot_tag       [NUM_TIMERS];
   logic [TW-1:0]                      rot_deadline  [NUM_TIMERS];
   logic [TW-1:0]                      rot_reload    [NUM_TIMERS];

   // Head unit outputs.
   logic                               head_pend;
   logic                               pend_rest;
   logic                               head_nxt_live;
   logic [TW-1:0]                      head_nxt_deadline;
   logic                               head_free;

   logic [TAG_W+stb_pkg::TAG_PORT_BITS-1:0]      tag_ext;
   logic [SLOT_BITS+stb_pkg::SLOT_PORT_BITS-1:0] slot_ext;

   // Handshake.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;

   // Lowest free slot and table-full flag.
   assign table_full = &busy_ff;
   always_comb begin
      free_idx = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_idx = SLOT_BITS'(i);
         end
      end
   end

   assign new_tag      = req_timer_tag[TAG_W-1:0];
   assign new_deadline = stb_pkg::sat_add(now_ff, req_timeout_seconds);

   // Scan progress and pending status at the head.
   assign head_pend = pend_vec[0];
   assign pend_rest = |(pend_vec >> 1);

   // Cell controls.
   always_comb begin
      ctrl        = '0;
      ctrl.insert = req_fire && (req_operation == stb_pkg::OP_CREATE) && !table_full;
      ctrl.arm    = req_fire && (req_operation == stb_pkg::OP_TICK);
      ctrl.rotate = (state_ff == ST_SCAN) && (!head_pend || out_free);
   end

   // Chain of timer cells.
   assign all_live_chain[0] = 1'b1;

   genvar g;
   generate
      for (g = 0; g < NUM_TIMERS; g++) begin : g_cell
         // Insert source: the new timer at the head, else the lower neighbor.
         if (g == 0) begin : g_ins_head
            assign ins_live[g]     = 1'b1;
            assign ins_periodic[g] = req_periodic;
            assign ins_slot[g]     = free_idx;
            assign ins_tag[g]      = new_tag;
            assign ins_deadline[g] = new_deadline;
            assign ins_reload[g]   = req_timeout_seconds;
         end else begin : g_ins_prev
            assign ins_live[g]     = cell_live[g-1];
            assign ins_periodic[g] = cell_periodic[g-1];
            assign ins_slot[g]     = cell_slot[g-1];
            assign ins_tag[g]      = cell_tag[g-1];
            assign ins_deadline[g] = cell_deadline[g-1];
            assign ins_reload[g]   = cell_reload[g-1];
         end

         // Rotate source: the processed head at the tail, else the upper neighbor.
         if (g == NUM_TIMERS - 1) begin : g_rot_tail
            assign rot_live[g]     = head_nxt_live;
            assign rot_mark[g]     = 1'b0;
            assign rot_periodic[g] = cell_periodic[0];
            assign rot_slot[g]     = cell_slot[0];
            assign rot_tag[g]      = cell_tag[0];
            assign rot_deadline[g] = head_nxt_deadline;
            assign rot_reload[g]   = cell_reload[0];
         end else begin : g_rot_next
            assign rot_live[g]     = cell_live[g+1];
            assign rot_mark[g]     = cell_mark[g+1];
            assign rot_periodic[g] = cell_periodic[g+1];
            assign rot_slot[g]     = cell_slot[g+1];
            assign rot_tag[g]      = cell_tag[g+1];
            assign rot_deadline[g] = cell_deadline[g+1];
            assign rot_reload[g]   = cell_reload[g+1];
         end

         stb_cell #(
            .SLOT_BITS (SLOT_BITS),
            .TAG_W     (TAG_W)
         ) u_cell (
            .clock              (clock),
            .reset              (reset),
            .ctrl               (ctrl),
            .now_seconds        (now_ff),
            .chain_all_live_in  (all_live_chain[g]),
            .chain_all_live_out (all_live_chain[g+1]),
            .ins_live           (ins_live[g]),
            .ins_periodic       (ins_periodic[g]),
            .ins_slot           (ins_slot[g]),
            .ins_tag            (ins_tag[g]),
            .ins_deadline       (ins_deadline[g]),
            .ins_reload         (ins_reload[g]),
            .rot_live           (rot_live[g]),
            .rot_mark           (rot_mark[g]),
            .rot_periodic       (rot_periodic[g]),
            .rot_slot           (rot_slot[g]),
            .rot_tag            (rot_tag[g]),
            .rot_deadline       (rot_deadline[g]),
            .rot_reload         (rot_reload[g]),
            .cur_live           (cell_live[g]),
            .cur_mark           (cell_mark[g]),
            .cur_periodic       (cell_periodic[g]),
            .cur_slot           (cell_slot[g]),
            .cur_tag            (cell_tag[g]),
            .cur_deadline       (cell_deadline[g]),
            .cur_reload         (cell_reload[g]),
            .pend               (pend_vec[g])
         );
      end
   endgenerate

   // Due timers at the head are retired or reloaded on their way to the tail.
   stb_head u_head (
      .head_live     (cell_live[0]),
      .head_periodic (cell_periodic[0]),
      .head_pend     (head_pend),
      .head_deadline (cell_deadline[0]),
      .head_reload   (cell_reload[0]),
      .now_seconds   (now_ff),
      .nxt_live      (head_nxt_live),
      .nxt_deadline  (head_nxt_deadline),
      .free_slot     (head_free)
   );

   // Scan sequencer, time and slot busy bits.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      now_in   = now_ff;
      busy_in  = busy_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.arm) begin
               now_in   = stb_pkg::sat_add(now_ff, TW'(1));
               step_in  = '0;
               state_in = ST_SCAN;
            end
            if (ctrl.insert) begin
               busy_in[free_idx] = 1'b1;
            end
         end
         ST_SCAN: begin
            if (ctrl.rotate) begin
               if (head_free) begin
                  busy_in[cell_slot[0]] = 1'b0;
               end
               if (step_ff == LAST_STEP) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;
      if (req_fire && (req_operation == stb_pkg::OP_CREATE)) begin
         rsp_valid_in = 1'b1;
         rsp_tag_in   = new_tag;
         rsp_last_in  = 1'b1;
         if (table_full) begin
            rsp_kind_in = stb_pkg::KIND_FULL;
            rsp_slot_in = '0;
         end else begin
            rsp_kind_in = stb_pkg::KIND_ACCEPTED;
            rsp_slot_in = free_idx;
         end
      end else if (ctrl.rotate && head_pend) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = stb_pkg::KIND_EXPIRED;
         rsp_tag_in   = cell_tag[0];
         rsp_slot_in  = cell_slot[0];
         rsp_last_in  = !pend_rest;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         now_ff       <= '0;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         now_ff       <= now_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Fit the stored tag and slot number to the port widths.
   assign tag_ext  = {{stb_pkg::TAG_PORT_BITS{1'b0}}, rsp_tag_ff};
   assign slot_ext = {{stb_pkg::SLOT_PORT_BITS{1'b0}}, rsp_slot_ff};

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_expired_tag = tag_ext[stb_pkg::TAG_PORT_BITS-1:0];
   assign rsp_slot_index  = slot_ext[stb_pkg::SLOT_PORT_BITS-1:0];
   assign rsp_last        = rsp_last_ff;

   // Assertions.
   `STB_ASSERT_SAME(a_idle_during_scan, clock, reset, state_ff == ST_SCAN, !req_ready, "request taken during a tick scan")
   `STB_ASSERT_SAME(a_busy_matches_cells, clock, reset, 1'b1, $countones(busy_ff) == $countones(cell_live), "slot busy bits disagree with live cells")
   `STB_ASSERT_NEXT(a_last_clears_pending, clock, reset, ctrl.rotate && head_pend && !pend_rest, pend_vec == '0, "due timer left after the last expiry")

endmodule

// File: sim/tb_software_timer_bank.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Software timer bank testbench
// Drives create and tick transactions into the timer bank with random idle
// gaps on both sides and checks every response against a behavioral copy of
// the timer table kept here. Directed tests cover expiry order, periodic
// reload, zero timeouts, deadline saturation and the table-full answer;
// random tests cover mixed traffic with and without idling.
// ----------------------------------------------------------------------------
module tb_software_timer_bank;

   localparam int NUM_TIMERS = 16;
   localparam int TAG_BITS   = 16;
   localparam int MAX_SHOWN  = 10;

   // One response as the bank reports it.
   typedef struct packed {
      logic [stb_pkg::KIND_BITS-1:0]      kind;
      logic [stb_pkg::TAG_PORT_BITS-1:0]  tag;
      logic [stb_pkg::SLOT_PORT_BITS-1:0] slot;
      logic                               last;
   } timer_rsp_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic                                req_operation;
   logic [stb_pkg::TIME_BITS-1:0]       req_timeout_seconds;
   logic                                req_periodic;
   logic [stb_pkg::TAG_PORT_BITS-1:0]   req_timer_tag;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [stb_pkg::KIND_BITS-1:0]       rsp_kind;
   logic [stb_pkg::TAG_PORT_BITS-1:0]   rsp_expired_tag;
   logic [stb_pkg::SLOT_PORT_BITS-1:0]  rsp_slot_index;
   logic                                rsp_last;

   // Behavioral copy of the timer table.
   logic [stb_pkg::TIME_BITS-1:0]     seconds_now;
   logic                              timer_live     [NUM_TIMERS];
   logic                              timer_periodic [NUM_TIMERS];
   logic [stb_pkg::TIME_BITS-1:0]     timer_deadline [NUM_TIMERS];
   logic [stb_pkg::TIME_BITS-1:0]     timer_reload   [NUM_TIMERS];
   logic [stb_pkg::TAG_PORT_BITS-1:0] timer_tag      [NUM_TIMERS];
   int                                timer_age[$];   // slot numbers, oldest first

   timer_rsp_type pending_rsps[$];

   bit steady_mode = 1'b0;
   int mismatch_count = 0;
   int creates_sent = 0;
   int ticks_sent = 0;
   int accepted_seen = 0;
   int full_seen = 0;
   int expired_seen = 0;

   software_timer_bank #(
      .NUM_TIMERS(NUM_TIMERS),
      .TAG_BITS  (TAG_BITS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_timeout_seconds(req_timeout_seconds),
      .req_periodic       (req_periodic),
      .req_timer_tag      (req_timer_tag),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_expired_tag    (rsp_expired_tag),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_last           (rsp_last)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The response side stalls about ten percent of the time, except in steady mode.
   always @(posedge clock) begin
      rsp_ready <= steady_mode || ($urandom_range(0, 99) >= 10);
   end

   // Seconds arithmetic clamps at the all-ones value.
   function automatic logic [stb_pkg::TIME_BITS-1:0] add_clamped(
         input logic [stb_pkg::TIME_BITS-1:0] a,
         input logic [stb_pkg::TIME_BITS-1:0] b);
      logic [stb_pkg::TIME_BITS:0] total;
      total = {1'b0, a} + {1'b0, b};
      return total[stb_pkg::TIME_BITS] ? '1 : total[stb_pkg::TIME_BITS-1:0];
   endfunction

   function automatic int periodic_live_count();
      int n;
      n = 0;
      foreach (timer_live[s])
         if (timer_live[s] && timer_periodic[s]) n++;
      return n;
   endfunction

   // Apply one accepted transaction to the table copy and queue its responses.
   task automatic predict_timer_rsps(input logic op,
                                     input logic [stb_pkg::TIME_BITS-1:0] timeout,
                                     input logic per,
                                     input logic [stb_pkg::TAG_PORT_BITS-1:0] tag);
      int            slot;
      int            first_new;
      int            survivors[$];
      timer_rsp_type r;
      if (op == stb_pkg::OP_CREATE) begin
         // The lowest free slot takes the new timer.
         slot = -1;
         for (int s = NUM_TIMERS - 1; s >= 0; s--)
            if (!timer_live[s]) slot = s;
         if (slot < 0) begin
            r = '{stb_pkg::KIND_FULL, tag, '0, 1'b1};
         end else begin
            timer_live[slot]     = 1'b1;
            timer_periodic[slot] = per;
            timer_reload[slot]   = timeout;
            timer_deadline[slot] = add_clamped(seconds_now, timeout);
            timer_tag[slot]      = tag;
            timer_age.push_back(slot);
            r = '{stb_pkg::KIND_ACCEPTED, tag, stb_pkg::SLOT_PORT_BITS'(slot), 1'b1};
         end
         pending_rsps.push_back(r);
      end else begin
         // Advance time, then report due timers from newest to oldest.
         seconds_now = add_clamped(seconds_now, stb_pkg::TIME_BITS'(1));
         first_new = pending_rsps.size();
         for (int k = timer_age.size() - 1; k >= 0; k--) begin
            slot = timer_age[k];
            if (timer_deadline[slot] <= seconds_now) begin
               r = '{stb_pkg::KIND_EXPIRED, timer_tag[slot],
                     stb_pkg::SLOT_PORT_BITS'(slot), 1'b0};
               pending_rsps.push_back(r);
               if (timer_periodic[slot])
                  timer_deadline[slot] = add_clamped(timer_reload[slot], seconds_now);
               else
                  timer_live[slot] = 1'b0;
            end
         end
         foreach (timer_age[k])
            if (timer_live[timer_age[k]]) survivors.push_back(timer_age[k]);
         timer_age = survivors;
         if (pending_rsps.size() > first_new) pending_rsps[$].last = 1'b1;
      end
   endtask

   // Send one transaction, with an occasional idle gap in front of it.
   task automatic send_request(input logic op,
                               input logic [stb_pkg::TIME_BITS-1:0] timeout,
                               input logic per,
                               input logic [stb_pkg::TAG_PORT_BITS-1:0] tag);
      int gap;
      gap = (!steady_mode && $urandom_range(0, 99) < 10) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_operation       <= op;
      req_timeout_seconds <= timeout;
      req_periodic        <= per;
      req_timer_tag       <= tag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_timer_rsps(op, timeout, per, tag);
      if (op == stb_pkg::OP_CREATE) creates_sent++;
      else ticks_sent++;
   endtask

   task automatic send_create(input logic [stb_pkg::TIME_BITS-1:0] timeout,
                              input logic per,
                              input logic [stb_pkg::TAG_PORT_BITS-1:0] tag);
      send_request(stb_pkg::OP_CREATE, timeout, per, tag);
   endtask

   // Tick transactions carry random data in the fields they do not use.
   task automatic send_tick();
      send_request(stb_pkg::OP_TICK, $urandom, 1'($urandom), 16'($urandom));
   endtask

   task automatic wait_for_rsps();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   // Zero timeouts, expiry order, periodic reload and a tick with nothing due.
   task automatic test_basic_expiry();
      send_tick();
      send_create(32'd0, 1'b0, 16'h0000);
      send_tick();
      send_create(32'd0, 1'b1, 16'hFFFF);
      send_create(32'd1, 1'b0, 16'h5A5A);
      send_create(32'd3, 1'b0, 16'hA5A5);
      repeat (3) send_tick();
      send_create(32'd2, 1'b1, 16'h1234);
      repeat (4) send_tick();
      wait_for_rsps();
   endtask

   // Mixed creates and ticks with short timeouts so that timers keep expiring.
   task automatic test_random_traffic(input int count);
      logic [stb_pkg::TIME_BITS-1:0] timeout;
      logic                          per;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 55) begin
            send_tick();
         end else begin
            timeout = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                  : $urandom_range(0, 6);
            per = (periodic_live_count() < 4) && ($urandom_range(0, 3) == 0);
            send_create(timeout, per, 16'($urandom));
         end
      end
      wait_for_rsps();
   endtask

   // Same traffic with both sides running flat out.
   task automatic test_steady_stream(input int count);
      steady_mode = 1'b1;
      test_random_traffic(count);
      steady_mode = 1'b0;
   endtask

   // Fill the table with timers that never come due, including saturated
   // deadlines, then check the table-full answer and that ticks still work.
   task automatic test_table_full();
      logic [stb_pkg::TIME_BITS-1:0] far_timeouts[5];
      int                            n;
      far_timeouts = '{32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                       32'h8000_0000, 32'h7FFF_FFFF};
      n = 0;
      while (timer_age.size() < NUM_TIMERS) begin
         send_create((n < 5) ? far_timeouts[n] : ($urandom | 32'h8000_0000),
                     1'(n), 16'($urandom));
         n++;
      end
      send_create(32'd0, 1'b0, 16'hFFFF);
      send_create(32'hFFFF_FFFF, 1'b1, 16'h0000);
      repeat (3) send_tick();
      send_create(32'd1, 1'b0, 16'($urandom));
      send_tick();
      wait_for_rsps();
   endtask

   // Compare each response with the oldest one still expected.
   always @(posedge clock) begin : rsp_check
      timer_rsp_type got;
      timer_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_kind, rsp_expired_tag, rsp_slot_index, rsp_last};
         case (got.kind)
            stb_pkg::KIND_ACCEPTED: accepted_seen++;
            stb_pkg::KIND_FULL:     full_seen++;
            stb_pkg::KIND_EXPIRED:  expired_seen++;
            default: ;
         endcase
         if (pending_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
               $display("%0t: response with none expected: kind %0d tag %h slot %0d last %0b",
                        $realtime, got.kind, got.tag, got.slot, got.last);
         end else begin
            want = pending_rsps.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN)
                  $display({"%0t: mismatch: expected kind %0d tag %h slot %0d last %0b,",
                            " got kind %0d tag %h slot %0d last %0b"},
                           $realtime, want.kind, want.tag, want.slot, want.last,
                           got.kind, got.tag, got.slot, got.last);
            end
         end
      end
   end

   // Main sequence.
   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_operation       = stb_pkg::OP_CREATE;
      req_timeout_seconds = '0;
      req_periodic        = 1'b0;
      req_timer_tag       = '0;
      seconds_now         = '0;
      foreach (timer_live[s]) timer_live[s] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_basic_expiry();
      test_random_traffic(190);
      test_steady_stream(60);
      test_table_full();

      // Let any scan still in progress finish before the final verdict.
      repeat (4 * NUM_TIMERS) @(posedge clock);
      if (pending_rsps.size() != 0) mismatch_count++;
      $display("Sent %0d creates and %0d ticks; seen %0d accepted, %0d table full, %0d expiries.",
               creates_sent, ticks_sent, accepted_seen, full_seen, expired_seen);
      $display("Mismatches: %0d.", mismatch_count);
      if (mismatch_count == 0)
         $display("tb_software_timer_bank: PASS");
      else
         $display("tb_software_timer_bank: FAIL");
      $finish;
   end

   // Watchdog in case the bank stops answering.
   initial begin
      #(5_000_000);
      $display("tb_software_timer_bank: FAIL");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/stb_pkg.sv
rtl/core/stb_cell.sv
rtl/core/stb_head.sv
rtl/core/software_timer_bank.sv
sim/tb_software_timer_bank.sv
